// File: hdl/aesc_pkg.sv
// Shared types, constants and AES round functions for the CBC encrypt core.
package aesc_pkg;

   localparam int BLOCK_BYTES = 16;

   // configuration register indexes
   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [1:0] CSR_IV_HIGH  = 2'd2;
   localparam logic [1:0] CSR_IV_LOW   = 2'd3;

   localparam logic [63:0] IV_HIGH_RESET = 64'h3132_3300_0000_0000;
   localparam logic [63:0] IV_LOW_RESET  = 64'h0;
   localparam logic [7:0]  FULL_PAD      = 8'h10;
   localparam logic [3:0]  LAST_ROUND    = 4'd10;

   // one block handed from the front to the engine
   typedef struct packed {
      logic [127:0] data;
      logic         final_blk;
   } job_type;

   localparam logic [7:0] SBOX [0:255] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] rnd);
      logic [7:0] v;
      case (rnd)
         4'd1:    v = 8'h01;
         4'd2:    v = 8'h02;
         4'd3:    v = 8'h04;
         4'd4:    v = 8'h08;
         4'd5:    v = 8'h10;
         4'd6:    v = 8'h20;
         4'd7:    v = 8'h40;
         4'd8:    v = 8'h80;
         4'd9:    v = 8'h1B;
         4'd10:   v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // next round key from the current one
   function automatic logic [127:0] key_next(input logic [127:0] w, input logic [7:0] rc);
      logic [31:0] w3;
      logic [31:0] t;
      logic [31:0] n0;
      logic [31:0] n1;
      logic [31:0] n2;
      logic [31:0] n3;
      w3 = w[31:0];
      t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
           ^ {rc, 24'h0};
      n0 = w[127:96] ^ t;
      n1 = w[95:64] ^ n0;
      n2 = w[63:32] ^ n1;
      n3 = w3 ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   // SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey;
   // byte i sits at bits [127-8i -: 8], column c row r is byte 4c+r
   function automatic logic [127:0] aes_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic last);
      logic [7:0]   t [16];
      logic [127:0] o;
      logic [7:0]   a0;
      logic [7:0]   a1;
      logic [7:0]   a2;
      logic [7:0]   a3;
      logic [7:0]   al;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[4*c+r] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c];
         a1 = t[4*c+1];
         a2 = t[4*c+2];
         a3 = t[4*c+3];
         al = a0 ^ a1 ^ a2 ^ a3;
         if (last) begin
            o[127-32*c -: 32] = {a0, a1, a2, a3};
         end else begin
            o[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                 a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
         end
      end
      return o ^ rk;
   endfunction

endpackage

// File: hdl/aesc_front.sv
// Byte gathering and PKCS#7 padding front end.
module aesc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tuser,
   input  logic              req_tlast,
   output logic              push,
   output aesc_pkg::job_type push_job,
   input  logic              queue_full
);

   logic [7:0] buf_ff [aesc_pkg::BLOCK_BYTES];
   logic [7:0] buf_in [aesc_pkg::BLOCK_BYTES];
   logic [3:0] fill_ff, fill_in;
   logic       pend_ff, pend_in;
   logic       take;
   logic [4:0] held;
   logic [7:0] pad;
   logic [127:0] raw, padded;

   assign req_tready = !pend_ff && !queue_full;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      buf_in = buf_ff;
      if (take && req_tuser) begin
         buf_in[fill_ff] = req_tdata;
      end
      held = {1'b0, fill_ff} + {4'd0, req_tuser};
      pad  = 8'd16 - {3'd0, held};
      for (int i = 0; i < aesc_pkg::BLOCK_BYTES; i++) begin
         raw[127-8*i -: 8]    = buf_in[i];
         padded[127-8*i -: 8] = (5'(i) < held) ? buf_in[i] : pad;
      end
   end

   always_comb begin
      push     = 1'b0;
      push_job = '{data: raw, final_blk: 1'b0};
      fill_in  = fill_ff;
      pend_in  = pend_ff;
      if (pend_ff) begin
         // full pad block after a block that ended exactly at the mark
         push_job = '{data: {16{aesc_pkg::FULL_PAD}}, final_blk: 1'b1};
         if (!queue_full) begin
            push    = 1'b1;
            pend_in = 1'b0;
         end
      end else if (take) begin
         if (held == 5'd16) begin
            push    = 1'b1;
            fill_in = 4'd0;
            pend_in = req_tlast;
         end else if (req_tlast) begin
            push     = 1'b1;
            push_job = '{data: padded, final_blk: 1'b1};
            fill_in  = 4'd0;
         end else begin
            fill_in = held[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         fill_ff <= 4'd0;
         pend_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// File: hdl/aesc_queue.sv
// Two-entry block queue between front end and cipher engine.
module aesc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  aesc_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output aesc_pkg::job_type pop_job
);

   aesc_pkg::job_type slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_pop;

   assign full      = cnt_ff == 2'd2;
   assign pop_valid = cnt_ff != 2'd0;
   assign pop_job   = slot_ff[rd_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hdl/aesc_engine.sv
// Round-iterative AES-128 engine with CBC chaining and result register.
module aesc_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  aesc_pkg::job_type job,
   output logic              job_pop,
   input  logic [127:0]      key,
   input  logic [127:0]      iv,
   input  logic              iv_hi_load,
   input  logic              iv_lo_load,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [127:0]      rsp_tdata,
   output logic              rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type    st_ff, st_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [127:0] blk_ff, blk_in;
   logic [127:0] rk_ff, rk_in;
   logic [127:0] chain_ff, chain_in;
   logic         fin_ff, fin_in;
   logic         ov_ff, ov_in;
   logic [127:0] od_ff, od_in;
   logic         ol_ff, ol_in;
   logic         out_free;

   assign out_free   = !ov_ff || rsp_tready;
   assign job_pop    = (st_ff == ST_IDLE) && job_valid;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {od_ff[63:0], od_ff[127:64]};
   assign rsp_tlast  = ol_ff;

   always_comb begin
      st_in    = st_ff;
      rnd_in   = rnd_ff;
      blk_in   = blk_ff;
      rk_in    = rk_ff;
      chain_in = chain_ff;
      fin_in   = fin_ff;
      ov_in    = ov_ff && !rsp_tready;
      od_in    = od_ff;
      ol_in    = ol_ff;
      if (iv_hi_load) chain_in[127:64] = iv[127:64];
      if (iv_lo_load) chain_in[63:0]   = iv[63:0];
      case (st_ff)
         ST_IDLE: begin
            if (job_valid) begin
               blk_in = job.data ^ chain_ff ^ key;
               rk_in  = key;
               fin_in = job.final_blk;
               rnd_in = 4'd1;
               st_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            rk_in  = aesc_pkg::key_next(rk_ff, aesc_pkg::rcon(rnd_ff));
            blk_in = aesc_pkg::aes_round(blk_ff, rk_in, rnd_ff == aesc_pkg::LAST_ROUND);
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == aesc_pkg::LAST_ROUND) st_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               ov_in    = 1'b1;
               od_in    = blk_ff;
               ol_in    = fin_ff;
               chain_in = fin_ff ? iv : blk_ff;
               st_in    = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
      blk_ff <= blk_in;
      rk_ff  <= rk_in;
      fin_ff <= fin_in;
      od_ff  <= od_in;
      ol_ff  <= ol_in;
      if (reset) begin
         st_ff    <= ST_IDLE;
         ov_ff    <= 1'b0;
         chain_ff <= {aesc_pkg::IV_HIGH_RESET, aesc_pkg::IV_LOW_RESET};
      end else begin
         st_ff    <= st_in;
         ov_ff    <= ov_in;
         chain_ff <= chain_in;
      end
   end

endmodule

// File: hdl/aes128_cbc_encrypt_core.sv
// Top level of the AES-128 CBC encryptor with PKCS#7 padding.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata plain_byte, tuser carries_byte,
//          |           |                      | tlast message_end
//  rsp     | out       | rsp_tvalid/tready    | tdata {cipher_low, cipher_high}, tlast final_block
//  csr     | in        | csr_we               | csr_addr index, csr_wdata value
//
// Bytes are taken one per cycle while req_tready is high. A full or padded
// block enters a two-entry queue; the engine then whitens it, runs the
// rounds (one shared round unit with on-the-fly key expansion) and hands
// the result off, one block at a time, while the queue holds the next ones.
// A block that ends exactly at the end mark is followed by a full pad block;
// req_tready drops while it waits and while the queue is full; a stalled
// result holds in the output register. Reset is synchronous and loads the
// default key and IV; it clears control state only.
module aes128_cbc_encrypt_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] plain_byte
   input  logic         req_tuser,   // [0] carries_byte
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] cipher_high, [127:64] cipher_low
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [63:0]  csr_wdata
);

   logic [63:0] key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic        iv_hi_load_in, iv_lo_load_in;
   logic        iv_hi_load_ff, iv_lo_load_ff;
   logic        push, full, pop, pop_valid;
   aesc_pkg::job_type push_job, pop_job;

   assign iv_hi_load_in = csr_we && (csr_addr == aesc_pkg::CSR_IV_HIGH);
   assign iv_lo_load_in = csr_we && (csr_addr == aesc_pkg::CSR_IV_LOW);

   // hold the configuration registers; reload the chain in the cycle after an IV
   // write, once the IV register holds the new value
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff     <= 64'h0;
         key_lo_ff     <= 64'h0;
         iv_hi_ff      <= aesc_pkg::IV_HIGH_RESET;
         iv_lo_ff      <= aesc_pkg::IV_LOW_RESET;
         iv_hi_load_ff <= 1'b0;
         iv_lo_load_ff <= 1'b0;
      end else begin
         iv_hi_load_ff <= iv_hi_load_in;
         iv_lo_load_ff <= iv_lo_load_in;
         if (csr_we) begin
            case (csr_addr)
               aesc_pkg::CSR_KEY_HIGH: key_hi_ff <= csr_wdata;
               aesc_pkg::CSR_KEY_LOW:  key_lo_ff <= csr_wdata;
               aesc_pkg::CSR_IV_HIGH:  iv_hi_ff  <= csr_wdata;
               aesc_pkg::CSR_IV_LOW:   iv_lo_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   aesc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_job   (push_job),
      .queue_full (full)
   );

   aesc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_job   (pop_job)
   );

   aesc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_pop    (pop),
      .key        ({key_hi_ff, key_lo_ff}),
      .iv         ({iv_hi_ff, iv_lo_ff}),
      .iv_hi_load (iv_hi_load_ff),
      .iv_lo_load (iv_lo_load_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hdl/aesc_checker.sv
// Port-level checks for the CBC encrypt core, bound to the top level.
module aesc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("front not ready after reset");

endmodule

bind aes128_cbc_encrypt_core aesc_checker u_aesc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: dv/tb_top.sv
// Self-checking testbench for the AES-128 CBC encrypt core with PKCS#7 padding.
`timescale 1ns / 1ps
module tb_top;

   typedef struct {
      logic [7:0] plain_byte;
      logic       carries_byte;
      logic       message_end;
   } byte_word_type;

   typedef struct {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
      logic        final_block;
   } cipher_word_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] plain_byte
   logic         req_tuser;   // [0] carries_byte
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // [63:0] cipher_high, [127:64] cipher_low
   logic         rsp_tlast;
   logic         csr_we;
   logic [1:0]   csr_addr;
   logic [63:0]  csr_wdata;

   aes128_cbc_encrypt_core u_dut (.*);

   // cipher model state, kept in step with the core
   logic [7:0]   ref_sbox [0:255];
   logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
   logic [31:0]  sched [0:43];
   logic [7:0]   gather [0:15];
   int unsigned  gather_cnt;
   logic [63:0]  chain_hi, chain_lo;

   byte_word_type   pending_bytes [$];
   cipher_word_type cipher_expected [$];

   int unsigned  mismatches;
   int unsigned  blocks_seen;
   int unsigned  words_sent;
   int unsigned  messages_sent;
   bit           no_idle;
   bit           sender_hold;
   bit           hold_rsp;
   bit           hold_taken;
   int unsigned  hold_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [7:0] gf2(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
   endfunction

   // rebuild the 44-word key schedule from the held key
   function automatic void expand_schedule();
      logic [31:0] t;
      logic [31:0] rc;
      rc = 32'h0100_0000;
      sched[0] = key_hi_q[63:32];
      sched[1] = key_hi_q[31:0];
      sched[2] = key_lo_q[63:32];
      sched[3] = key_lo_q[31:0];
      for (int i = 4; i < 44; i++) begin
         t = sched[i-1];
         if (i % 4 == 0) begin
            t = {ref_sbox[t[23:16]], ref_sbox[t[15:8]], ref_sbox[t[7:0]],
                 ref_sbox[t[31:24]]} ^ rc;
            rc = (rc == 32'h8000_0000) ? 32'h1B00_0000 : {gf2(rc[31:24]), 24'h0};
         end
         sched[i] = sched[i-4] ^ t;
      end
   endfunction

   function automatic void apply_csr(input logic [1:0] idx, input logic [63:0] val);
      case (idx)
         aesc_pkg::CSR_KEY_HIGH: begin
            key_hi_q = val;
            expand_schedule();
         end
         aesc_pkg::CSR_KEY_LOW: begin
            key_lo_q = val;
            expand_schedule();
         end
         aesc_pkg::CSR_IV_HIGH: begin
            iv_hi_q = val;
            chain_hi = val;
         end
         default: begin
            iv_lo_q = val;
            chain_lo = val;
         end
      endcase
   endfunction

   // chain the gathered block, encrypt it and queue the ciphertext
   function automatic void encrypt_block(input logic fin);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] cv;
      cipher_word_type w;
      cv = {chain_hi, chain_lo};
      for (int i = 0; i < 16; i++) s[i] = gather[i] ^ cv[127-8*i -: 8];
      for (int rnd = 0; rnd <= 10; rnd++) begin
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  t[4*c+r] = ref_sbox[s[4*((c+r)%4)+r]];
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               al = a0 ^ a1 ^ a2 ^ a3;
               if (rnd == 10) begin
                  s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
               end else begin
                  s[4*c]   = a0 ^ al ^ gf2(a0 ^ a1);
                  s[4*c+1] = a1 ^ al ^ gf2(a1 ^ a2);
                  s[4*c+2] = a2 ^ al ^ gf2(a2 ^ a3);
                  s[4*c+3] = a3 ^ al ^ gf2(a3 ^ a0);
               end
            end
         end
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               s[4*c+r] ^= sched[rnd*4+c][31-8*r -: 8];
      end
      for (int i = 0; i < 8; i++) begin
         w.cipher_high[63-8*i -: 8] = s[i];
         w.cipher_low[63-8*i -: 8]  = s[i+8];
      end
      w.final_block = fin;
      chain_hi = w.cipher_high;
      chain_lo = w.cipher_low;
      cipher_expected.insert(cipher_expected.size(), w);
   endfunction

   function automatic void absorb_byte(input byte_word_type b);
      logic [7:0] pad;
      if (b.carries_byte) begin
         gather[gather_cnt] = b.plain_byte;
         if (gather_cnt == 15) begin
            encrypt_block(1'b0);
            gather_cnt = 0;
         end else begin
            gather_cnt++;
         end
      end
      if (b.message_end) begin
         pad = 8'(16 - gather_cnt);
         for (int i = gather_cnt; i < 16; i++) gather[i] = pad;
         encrypt_block(1'b1);
         gather_cnt = 0;
         chain_hi = iv_hi_q;
         chain_lo = iv_lo_q;
         messages_sent++;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   // driver: advance to the next pending word once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_byte('{req_tdata, req_tuser, req_tlast});
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() > 0 && !sender_hold &&
                (no_idle || $urandom_range(99) >= 7)) begin
               byte_word_type b;
               b = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= b.plain_byte;
               req_tuser  <= b.carries_byte;
               req_tlast  <= b.message_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with one long hold counted here when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         hold_taken  <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_rsp && !hold_taken) begin
         hold_taken  <= 1'b1;
         hold_cycles <= 400;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 7);
      end
   end

   // monitor: compare every accepted block with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cipher_expected.size() == 0) begin
            report_mismatch("unexpected block", rsp_tdata[63:0], 64'h0);
         end else begin
            cipher_word_type e;
            e = cipher_expected.pop_front();
            if (rsp_tdata[63:0] !== e.cipher_high)
               report_mismatch("cipher_high", rsp_tdata[63:0], e.cipher_high);
            if (rsp_tdata[127:64] !== e.cipher_low)
               report_mismatch("cipher_low", rsp_tdata[127:64], e.cipher_low);
            if (rsp_tlast !== e.final_block)
               report_mismatch("final_block", 64'(rsp_tlast), 64'(e.final_block));
         end
         blocks_seen++;
      end
   end

   task automatic push_word(input logic [7:0] d, input logic c, input logic e);
      byte_word_type b;
      b = '{d, c, e};
      pending_bytes.insert(pending_bytes.size(), b);
   endtask

   // drain everything, then give the engine time to settle
   task automatic wait_idle();
      wait (pending_bytes.size() == 0 && !req_tvalid);
      wait (cipher_expected.size() == 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      apply_csr(idx, val);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic push_message(input int len, input bit bare_end);
      for (int i = 0; i < len; i++) begin
         // drop in idle words now and then
         if ($urandom_range(19) == 0) push_word(8'($urandom), 1'b0, 1'b0);
         push_word(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
      end
      if (bare_end || len == 0) push_word(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic random_config();
      write_csr(aesc_pkg::CSR_KEY_HIGH, {$urandom, $urandom});
      write_csr(aesc_pkg::CSR_KEY_LOW, {$urandom, $urandom});
      write_csr(aesc_pkg::CSR_IV_HIGH, {$urandom, $urandom});
      write_csr(aesc_pkg::CSR_IV_LOW, {$urandom, $urandom});
   endtask

   initial begin
      int n;
      for (int i = 0; i < 256; i++) ref_sbox[i] = aesc_pkg::SBOX[i];
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_addr    = aesc_pkg::CSR_KEY_HIGH;
      csr_wdata   = '0;
      mismatches  = 0;
      blocks_seen = 0;
      words_sent  = 0;
      messages_sent = 0;
      no_idle     = 0;
      sender_hold = 0;
      hold_rsp    = 0;
      gather_cnt  = 0;
      key_hi_q = '0;
      key_lo_q = '0;
      iv_hi_q  = aesc_pkg::IV_HIGH_RESET;
      iv_lo_q  = aesc_pkg::IV_LOW_RESET;
      chain_hi = iv_hi_q;
      chain_lo = iv_lo_q;
      expand_schedule();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset key and IV, empty message, idle words, extremes
      push_word(8'h00, 1'b0, 1'b0);
      push_word(8'hFF, 1'b0, 1'b1);
      push_word(8'h00, 1'b1, 1'b0);
      push_word(8'hFF, 1'b1, 1'b1);
      for (int i = 0; i < 16; i++) push_word(i[0] ? 8'hFF : 8'h00, 1'b1, i == 15);
      wait_idle();

      // all-zero and all-one settings
      write_csr(aesc_pkg::CSR_KEY_HIGH, '1);
      write_csr(aesc_pkg::CSR_KEY_LOW, '1);
      write_csr(aesc_pkg::CSR_IV_HIGH, '1);
      write_csr(aesc_pkg::CSR_IV_LOW, '1);
      push_message(15, 1'b0);
      push_message(16, 1'b1);
      wait_idle();
      write_csr(aesc_pkg::CSR_KEY_HIGH, '0);
      write_csr(aesc_pkg::CSR_KEY_LOW, '0);
      write_csr(aesc_pkg::CSR_IV_HIGH, '0);
      write_csr(aesc_pkg::CSR_IV_LOW, '0);
      push_message(1, 1'b0);
      push_message(0, 1'b1);
      wait_idle();

      // long receiver hold while the sender keeps offering bytes
      random_config();
      no_idle = 1;
      push_message(80, 1'b0);
      @(posedge clock);
      hold_rsp = 1;
      wait_idle();
      no_idle = 0;

      // random phases, one fresh setting each
      for (int ph = 0; ph < 8; ph++) begin
         random_config();
         if (ph == 3) no_idle = 1;
         while (pending_bytes.size() < 220) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(40);
            push_message(n, $urandom_range(3) == 0);
         end
         wait_idle();
         no_idle = 0;
      end
      repeat (40) @(posedge clock);

      $display("Sent %0d words in %0d messages, checked %0d cipher blocks.",
               words_sent, messages_sent, blocks_seen);
      $display("Covered reset and extreme keys/IVs, bare end marks, idle words, backpressure.");
      if (mismatches == 0 && cipher_expected.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
